/* hdl/acfd_pkg.sv */
package acfd_pkg;

    localparam int DATA_MAX_DEF = 32;
    localparam int MIN_FRAME    = 7;
    localparam int COUNT_W      = 6;
    localparam int CMD_W        = 10;
    localparam int STATUS_W     = 3;
    localparam int RES_COUNT_W  = 6;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ENDING   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIGIT    = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [CMD_W-1:0]       command_code;
        logic [RES_COUNT_W-1:0] data_count;
        logic [7:0]             data_byte;
        logic                   data_valid;
        logic                   run_last;
    } out_item_t;

    // Frame verdict handed from the ingest side to the replay control.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CMD_W-1:0]    command;
    } frame_sum_t;

    // Value 0..15 of a hex digit, bit 4 set when the byte is no hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            if (c >= 8'h30 && c <= 8'h39)
                v = {1'b0, c[3:0]};
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
                v = {1'b0, c[3:0] + 4'd9};
            else
                v = 5'h10;
            return v;
        end
    endfunction

endpackage

/* hdl/acfd_dbuf.sv */
module acfd_dbuf #(
    parameter int DEPTH = acfd_pkg::DATA_MAX_DEF,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/acfd_ingest.sv */
module acfd_ingest #(
    parameter int DATA_MAX = acfd_pkg::DATA_MAX_DEF,
    parameter int AW       = 5,
    parameter int FW       = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  acfd_pkg::in_item_t   item,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [7:0]           wr_data,
    output acfd_pkg::frame_sum_t verdict,
    output logic [FW-1:0]        fill
);
    import acfd_pkg::*;

    localparam logic [FW-1:0] FILL_MAX = FW'(DATA_MAX);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         dl_reg [4];
    logic [7:0]         dl_next [4];
    logic [7:0]         sum_reg, sum_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic               derr_reg, derr_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               over_reg, over_next;

    logic       retire;
    logic       cmd_slot;
    logic       is_digit;
    logic [7:0] old_b;
    logic [13:0] cmd_wide;
    logic [4:0] hi, lo;

    always_comb
    begin
        old_b    = dl_reg[0];
        retire   = count_reg >= COUNT_W'(4);
        cmd_slot = count_reg < COUNT_W'(MIN_FRAME);
        is_digit = old_b >= 8'h30 && old_b <= 8'h39;
        cmd_wide = {1'b0, cmd_reg, 3'b000} + {3'b000, cmd_reg, 1'b0}
                 + {10'd0, old_b[3:0]};

        sum_next  = retire ? sum_reg + old_b : sum_reg;
        cmd_next  = (retire && cmd_slot && is_digit) ? cmd_wide[CMD_W-1:0] : cmd_reg;
        derr_next = derr_reg | (retire && cmd_slot && !is_digit);
        wr_en     = take && retire && !cmd_slot && (fill_reg < FILL_MAX);
        fill_next = (retire && !cmd_slot && (fill_reg < FILL_MAX)) ? fill_reg + 1'b1
                  : fill_reg;
        over_next = over_reg | (retire && !cmd_slot && (fill_reg == FILL_MAX));
        dl_next[0] = dl_reg[1];
        dl_next[1] = dl_reg[2];
        dl_next[2] = dl_reg[3];
        dl_next[3] = item.rx_byte;
        count_next = (count_reg == COUNT_SAT) ? count_reg : count_reg + 1'b1;

        // Judge the frame on the state as it stands after this byte.
        hi = hex_value(dl_next[0]);
        lo = hex_value(dl_next[1]);
        verdict.command = cmd_next;
        if (count_next < COUNT_W'(MIN_FRAME))
            verdict.status = ST_SHORT;
        else if (dl_next[2] != CHAR_CR || dl_next[3] != CHAR_LF)
            verdict.status = ST_ENDING;
        else if (hi[4] || lo[4])
            verdict.status = ST_DIGIT;
        else if ({hi[3:0], lo[3:0]} != sum_next)
            verdict.status = ST_MISMATCH;
        else if (derr_next)
            verdict.status = ST_DIGIT;
        else if (over_next)
            verdict.status = ST_OVERFLOW;
        else
            verdict.status = ST_OK;
    end

    assign wr_addr = fill_reg[AW-1:0];
    assign wr_data = old_b;
    assign fill    = fill_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                dl_reg[i] <= '0;
            end
            sum_reg  <= '0;
            cmd_reg  <= '0;
            derr_reg <= 1'b0;
            fill_reg <= '0;
            over_reg <= 1'b0;
        end
        else if (take)
        begin
            if (item.frame_end)
            begin
                count_reg <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    dl_reg[i] <= '0;
                end
                sum_reg  <= '0;
                cmd_reg  <= '0;
                derr_reg <= 1'b0;
                fill_reg <= '0;
                over_reg <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                for (int i = 0; i < 4; i++)
                begin
                    dl_reg[i] <= dl_next[i];
                end
                sum_reg  <= sum_next;
                cmd_reg  <= cmd_next;
                derr_reg <= derr_next;
                fill_reg <= fill_next;
                over_reg <= over_next;
            end
        end
    end

endmodule

/* hdl/ascii_checksum_frame_decoder.sv */
// A byte without the end flag is taken and gives no item.
// At a frame end, a failed or data-free frame passes through S_SINGLE and gives its one
// item once the output register is free; a frame with data reads each byte in S_READ and
// loads it in S_LOAD when the output register is free, as the data memory read is registered.
// Throughput: one input byte per cycle while no replay runs; input holds off from a
// frame end until the frame's last item is loaded into the output register.
module ascii_checksum_frame_decoder #(
    parameter int DATA_MAX = acfd_pkg::DATA_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  acfd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output acfd_pkg::out_item_t out_data
);
    import acfd_pkg::*;

    localparam int AW = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;
    localparam int FW = $clog2(DATA_MAX + 1);

    typedef enum logic [1:0] {
        S_IN,
        S_SINGLE,
        S_READ,
        S_LOAD
    } state_t;

    state_t          state_reg, state_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [FW-1:0]       cnt_reg, cnt_next;
    logic [FW-1:0]       idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    logic          take;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [7:0]    rd_data;
    frame_sum_t    verdict;
    logic [FW-1:0] fill;
    logic          out_free;
    logic          last;
    logic [FW-1:0] idx_inc;

    // Take a byte only between frames' replays.
    assign in_ready = (state_reg == S_IN);
    assign take     = in_valid && in_ready;

    acfd_ingest #(
        .DATA_MAX (DATA_MAX),
        .AW       (AW),
        .FW       (FW)
    ) u_ingest (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .item    (in_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .verdict (verdict),
        .fill    (fill)
    );

    acfd_dbuf #(
        .DEPTH (DATA_MAX),
        .AW    (AW)
    ) u_dbuf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign idx_inc  = idx_reg + 1'b1;
    assign last     = (idx_inc == cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        stat_next      = stat_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_en          = 1'b0;

        case (state_reg)
            S_IN:
            begin
                if (take && in_data.frame_end)
                begin
                    // Latch the verdict; drop the command when the frame fails.
                    stat_next = verdict.status;
                    idx_next  = '0;
                    if (verdict.status == ST_OK)
                    begin
                        cmd_next = verdict.command;
                        cnt_next = fill;
                    end
                    else
                    begin
                        cmd_next = '0;
                        cnt_next = '0;
                    end
                    if (verdict.status != ST_OK || fill == '0)
                        state_next = S_SINGLE;
                    else
                        state_next = S_READ;
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = stat_reg;
                    out_data_next.command_code  = cmd_reg;
                    out_data_next.data_count    = '0;
                    out_data_next.data_byte     = '0;
                    out_data_next.data_valid    = 1'b0;
                    out_data_next.run_last      = 1'b1;
                    state_next                  = S_IN;
                end
            end
            S_READ:
            begin
                // Issue the buffer read; data lands next cycle.
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = ST_OK;
                    out_data_next.command_code  = cmd_reg;
                    out_data_next.data_count    = RES_COUNT_W'(cnt_reg);
                    out_data_next.data_byte     = rd_data;
                    out_data_next.data_valid    = 1'b1;
                    out_data_next.run_last      = last;
                    idx_next                    = idx_inc;
                    state_next                  = last ? S_IN : S_READ;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            stat_reg      <= ST_OK;
            cmd_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            stat_reg      <= stat_next;
            cmd_reg       <= cmd_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* verif/ascii_checksum_frame_decoder_tb.sv */
`timescale 1ns / 100ps

module ascii_checksum_frame_decoder_tb;

    import acfd_pkg::*;

    localparam int DATA_MAX       = DATA_MAX_DEF;
    localparam int IDLE_LIMIT     = 4000;   // cycles with no item moving on either side
    localparam int LONG_HOLD      = 300;    // receiver hold-off used to back up the block
    localparam int TARGET_BYTES   = 200;
    localparam int TARGET_RESULTS = 50;

    // Shapes of frame that the random part builds.
    typedef enum int {
        FK_GOOD,
        FK_BAD_SUM,
        FK_BAD_HEX,
        FK_BAD_CMD,
        FK_BAD_END,
        FK_OVERFLOW,
        FK_SHORT,
        FK_NOISE
    } frame_kind_e;

    // Value 0..15 of an ASCII hex digit in either case, -1 for any other byte.
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    // Tracks the decoder's frame state and holds the result items it owes.
    class frame_scoreboard;
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         tail [4];      // last four bytes, entry 0 the oldest
        logic [7:0]         sum_so_far;    // sum of the bytes that left the tail
        logic [CMD_W-1:0]   cmd_value;
        bit                 cmd_bad;
        int                 fill;
        bit                 overflowed;
        logic [7:0]         payload [DATA_MAX];
        out_item_t          owed_items [$];
        int                 errors;
        int                 results_total;

        function new();
            foreach (payload[i]) payload[i] = 8'h00;
            errors = 0;
            results_total = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count = '0;
            foreach (tail[i]) tail[i] = 8'h00;
            sum_so_far = 8'h00;
            cmd_value  = '0;
            cmd_bad    = 1'b0;
            fill       = 0;
            overflowed = 1'b0;
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("%0t ns: %s", $time, what);
        endtask

        function void retire(input logic [7:0] b, input int idx);
            sum_so_far = sum_so_far + b;
            if (idx < 3) begin
                if (b >= "0" && b <= "9")
                    cmd_value = CMD_W'(cmd_value * 10 + (b - 8'h30));
                else
                    cmd_bad = 1'b1;
            end
            else if (fill < DATA_MAX) begin
                payload[fill] = b;
                fill++;
            end
            else begin
                overflowed = 1'b1;
            end
        endfunction

        function void push_owed(input logic [STATUS_W-1:0] st, input logic [CMD_W-1:0] cmd,
                                input int cnt, input logic [7:0] b, input bit dv,
                                input bit lst);
            out_item_t r;
            r.status       = st;
            r.command_code = cmd;
            r.data_count   = cnt[RES_COUNT_W-1:0];
            r.data_byte    = b;
            r.data_valid   = dv;
            r.run_last     = lst;
            owed_items.push_back(r);
            results_total++;
        endfunction

        // Advance the frame state by one accepted byte; at a frame end, queue
        // the run of result items that the frame owes.
        function void take_byte(input in_item_t item);
            logic [STATUS_W-1:0] st;
            int hi;
            int lo;
            if (byte_count >= 4)
                retire(tail[0], int'(byte_count) - 4);
            tail[0] = tail[1];
            tail[1] = tail[2];
            tail[2] = tail[3];
            tail[3] = item.rx_byte;
            if (byte_count != COUNT_SAT)
                byte_count++;
            if (!item.frame_end)
                return;

            hi = hex_nibble(tail[0]);
            lo = hex_nibble(tail[1]);
            if (byte_count < MIN_FRAME)
                st = ST_SHORT;
            else if (tail[2] != CHAR_CR || tail[3] != CHAR_LF)
                st = ST_ENDING;
            else if (hi < 0 || lo < 0)
                st = ST_DIGIT;
            else if (((hi << 4) | lo) != int'(sum_so_far))
                st = ST_MISMATCH;
            else if (cmd_bad)
                st = ST_DIGIT;
            else if (overflowed)
                st = ST_OVERFLOW;
            else
                st = ST_OK;

            if (st != ST_OK || fill == 0)
                push_owed(st, (st == ST_OK) ? cmd_value : '0, 0, 8'h00, 1'b0, 1'b1);
            else
                for (int k = 0; k < fill; k++)
                    push_owed(ST_OK, cmd_value, fill, payload[k], 1'b1, k == fill - 1);
            clear_frame();
        endfunction

        task check_field(input string name, input int got, input int want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        // Compare one accepted result item against the oldest owed item.
        task check_item(input out_item_t got);
            out_item_t want;
            if ($isunknown(got)) begin
                report_mismatch($sformatf("result item has unknown bits: %h", got));
                if (owed_items.size() != 0) void'(owed_items.pop_front());
                return;
            end
            if (owed_items.size() == 0) begin
                report_mismatch($sformatf("result item %h with nothing owed", got));
                return;
            end
            want = owed_items.pop_front();
            check_field("status",       got.status,       want.status);
            check_field("command_code", got.command_code, want.command_code);
            check_field("data_count",   got.data_count,   want.data_count);
            check_field("data_byte",    got.data_byte,    want.data_byte);
            check_field("data_valid",   got.data_valid,   want.data_valid);
            check_field("run_last",     got.run_last,     want.run_last);
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    frame_scoreboard sb = new();

    logic [7:0] frame_bytes [$];   // bytes of the frame being built
    int         bytes_sent  = 0;
    int         rx_hold     = 0;   // requested receiver hold-off, in cycles
    bit         tx_burst    = 1'b0;
    bit         rx_burst    = 1'b0;
    int         idle_cycles = 0;

    ascii_checksum_frame_decoder #(
        .DATA_MAX (DATA_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hold reset, then release it once for the whole run.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Monitor both handshakes at the edge: feed accepted bytes to the
    // predictor, check accepted results, and run the stall watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.take_byte(in_data);
            if (out_valid && out_ready)
                sb.check_item(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles, %0d items still owed",
                         IDLE_LIMIT, sb.owed_items.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: draw a random stall before each result item, with stretches of
    // no stall, and honor a long hold-off when the stimulus asks for one.
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            if (rx_hold != 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one byte after a random gap and hold it until it is accepted.
    // Leave valid high afterwards so back-to-back bytes need no extra edge.
    task automatic send_item(input logic [7:0] b, input logic lst);
        in_item_t item;
        int       gap;
        if ($urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.rx_byte   = b;
        item.frame_end = lst;
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_item(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit lower);
        if (n < 10) return 8'h30 + n;
        return (lower ? 8'h57 : 8'h37) + n;
    endfunction

    // Append the two checksum digits for the given sum, then CR LF.
    function automatic void close_frame(input logic [7:0] sum, input bit lower);
        frame_bytes.push_back(nibble_char(sum[7:4], lower));
        frame_bytes.push_back(nibble_char(sum[3:0], lower));
        frame_bytes.push_back(CHAR_CR);
        frame_bytes.push_back(CHAR_LF);
    endfunction

    function automatic logic [7:0] frame_sum();
        logic [7:0] s;
        s = 8'h00;
        foreach (frame_bytes[i]) s += frame_bytes[i];
        return s;
    endfunction

    // Build a complete frame with random content, then break it as the kind asks.
    task automatic build_frame(input frame_kind_e kind, input int n_data);
        logic [7:0] c;
        logic [7:0] sum;
        int         pos;
        int         which;
        frame_bytes.delete();
        repeat (3) frame_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
        if (kind == FK_BAD_CMD) begin
            // a non-digit command byte that still counts toward a correct checksum
            do c = 8'($urandom_range(0, 255)); while (c >= "0" && c <= "9");
            frame_bytes[$urandom_range(0, 2)] = c;
        end
        repeat (n_data) frame_bytes.push_back(8'($urandom_range(0, 255)));
        sum = frame_sum();
        if (kind == FK_BAD_SUM)
            sum += 8'($urandom_range(1, 255));
        close_frame(sum, 1'($urandom_range(0, 1)));
        if (kind == FK_BAD_HEX) begin
            pos = frame_bytes.size() - 4 + $urandom_range(0, 1);
            do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
            frame_bytes[pos] = c;
        end
        if (kind == FK_BAD_END) begin
            // break CR, LF or both
            which = $urandom_range(0, 2);
            if (which != 1) begin
                do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR);
                frame_bytes[frame_bytes.size() - 2] = c;
            end
            if (which != 0) begin
                do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
                frame_bytes[frame_bytes.size() - 1] = c;
            end
        end
    endtask

    // Drop valid so the last accepted byte is not offered again, then wait.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.owed_items.size() != 0) @(posedge clk);
    endtask

    // Main stimulus: directed frames, then random frames until enough bytes
    // and results have gone through.
    initial
    begin
        int          roll;
        int          n;
        int          frame_no;
        frame_kind_e kind;

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // Lone byte with every bit set and the end flag: too short.
        send_item(8'hFF, 1'b1);

        // Command 000 with data bytes 00 and FF, lowercase checksum.
        frame_bytes = {8'h30, 8'h30, 8'h30, 8'h00, 8'hFF};
        close_frame(frame_sum(), 1'b1);
        send_frame();

        // Command 999, no data, uppercase checksum.
        frame_bytes = {8'h39, 8'h39, 8'h39};
        close_frame(frame_sum(), 1'b0);
        send_frame();

        // Letter among the command digits, checksum still right.
        frame_bytes = {8'h30, 8'h41, 8'h31};
        close_frame(frame_sum(), 1'b0);
        send_frame();

        frame_no = 0;
        while (bytes_sent < TARGET_BYTES || sb.results_total < TARGET_RESULTS) begin
            frame_no++;

            // Hold the receiver off for a long stretch while frames keep
            // coming, so the block backs up and stalls its input.
            if (frame_no == 4)
                rx_hold = LONG_HOLD;

            // Pause the sender until every owed result item has arrived.
            if (frame_no == 10)
                wait_drained();

            roll = $urandom_range(0, 99);
            if      (roll < 50) kind = FK_GOOD;
            else if (roll < 58) kind = FK_BAD_SUM;
            else if (roll < 64) kind = FK_BAD_HEX;
            else if (roll < 70) kind = FK_BAD_CMD;
            else if (roll < 77) kind = FK_BAD_END;
            else if (roll < 83) kind = FK_OVERFLOW;
            else if (roll < 90) kind = FK_SHORT;
            else                kind = FK_NOISE;

            // One frame long enough to saturate the byte counter.
            if (frame_no == 7)
                kind = FK_OVERFLOW;

            case (kind)
                FK_SHORT:
                begin
                    n = $urandom_range(1, 6);
                    for (int i = 1; i <= n; i++)
                        send_item(8'($urandom_range(0, 255)), i == n);
                end
                FK_NOISE:
                begin
                    // Random bytes with random end flags; close on the last one
                    // so the next frame starts clean.
                    n = $urandom_range(1, 10);
                    for (int i = 1; i <= n; i++)
                        send_item(8'($urandom_range(0, 255)),
                                  (i == n) || ($urandom_range(0, 3) == 0));
                end
                FK_OVERFLOW:
                begin
                    n = (frame_no == 7) ? 60 : $urandom_range(DATA_MAX + 1, DATA_MAX + 8);
                    build_frame(kind, n);
                    send_frame();
                end
                default:
                begin
                    // Mostly small payloads, now and then the full buffer.
                    roll = $urandom_range(0, 9);
                    if (roll == 0)      n = DATA_MAX;
                    else if (roll == 1) n = $urandom_range(9, DATA_MAX);
                    else                n = $urandom_range(0, 8);
                    build_frame(kind, n);
                    send_frame();
                end
            endcase
        end

        wait_drained();
        // Let any stray extra result item show up before the verdict.
        repeat (32) @(posedge clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
